/* sv/pdhi_pkg.sv */
package pdhi_pkg;

  localparam int DATA_BYTES  = 64;
  localparam int EVENT_BYTES = 11;
  localparam int DATA_AW     = $clog2(DATA_BYTES);
  localparam int POS_W       = 7;
  localparam int CFG_W       = 16;

  localparam logic [POS_W-1:0] POS_MAX = 7'd127;

  typedef enum logic [3:0] {
    CMD_WRITE   = 4'd0,
    CMD_READ    = 4'd1,
    CMD_STOP    = 4'd2,
    CMD_BURST   = 4'd3,
    CMD_CHG_IN  = 4'd4,
    CMD_CHG_OUT = 4'd5,
    CMD_DEV_IN  = 4'd6,
    CMD_DEV_OUT = 4'd7,
    CMD_REINIT  = 4'd8
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_STRICT_LEN = 3'd0,
    CFG_BOOT_APP   = 3'd1,
    CFG_CHG_MV     = 3'd2,
    CFG_CHG_MA     = 3'd3,
    CFG_SRC_MV     = 3'd4,
    CFG_SRC_MA     = 3'd5
  } cfg_idx_t;

  localparam logic [7:0] ADDR_MODE  = 8'h03;
  localparam logic [7:0] ADDR_CMD1  = 8'h08;
  localparam logic [7:0] ADDR_DATA1 = 8'h09;
  localparam logic [7:0] ADDR_IEV   = 8'h14;
  localparam logic [7:0] ADDR_IMSK  = 8'h16;
  localparam logic [7:0] ADDR_ICLR  = 8'h18;
  localparam logic [7:0] ADDR_PDO   = 8'h34;
  localparam logic [7:0] ADDR_RDO   = 8'h35;
  localparam logic [7:0] ADDR_PSTAT = 8'h3F;

  localparam logic [31:0] FCC_PTCH = 32'h48435450;
  localparam logic [31:0] FCC_APP  = 32'h20505041;
  localparam logic [31:0] FCC_FAIL = 32'h444D4321;
  localparam logic [31:0] FCC_PBMS = 32'h734D4250;
  localparam logic [31:0] FCC_PBMC = 32'h634D4250;
  localparam logic [31:0] FCC_PBME = 32'h654D4250;

  localparam logic [7:0] PSTAT_SINK   = 8'h03 | (8'h02 << 2);
  localparam logic [7:0] PSTAT_SOURCE = 8'h01;

  // Reciprocals: floor(x / 25) for x below 2^15, floor(x / 5) for x below 2^13.
  localparam logic [15:0] MV_RECIP = 16'd41944;
  localparam logic [13:0] MA_RECIP = 14'd13108;

  typedef struct packed {
    logic       mem_sel;
    logic       mem_ok;
    logic [7:0] rd_byte;
    logic       nack;
    logic       irq_n;
    logic       app_mode;
  } stage_t;

endpackage

/* sv/usb_pd_controller_host_interface.sv */
// Channel   Direction  Handshake           Payload
// s_*       in         s_tvalid/s_tready   tuser: command; tdata: data_byte
// m_*       out        m_tvalid/m_tready   tdata: read_data, nack, irq_n, app_mode
// cfg_*     in         cfg_we              cfg_index, cfg_data
//
// One item is taken every cycle while s_tready is high; its result is registered
// first in the read stage, with the DATA1 memory read, then in the output register.
// Synchronous reset clears the control state and the DATA1 valid bits.
// s_tready falls only while both the read stage and the output register hold items.
module usb_pd_controller_host_interface (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [7:0]               s_tdata,   // [7:0] data_byte
  input  logic [3:0]               s_tuser,   // [3:0] command
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [15:0]              m_tdata,   // [7:0] read_data, [8] nack, [9] irq_n,
                                              // [10] app_mode, rest zero
  input  logic                     cfg_we,
  input  pdhi_pkg::cfg_idx_t       cfg_index,
  input  logic [pdhi_pkg::CFG_W-1:0] cfg_data
);
  import pdhi_pkg::*;

  logic        strict_len, boot_app_mode;
  logic [15:0] charger_mv, source_mv;
  logic [13:0] charger_ma, source_ma;

  logic             mode_is_app, mode_is_app_next;
  logic             cmd_failed, cmd_failed_next;
  logic [9:0]       mv_code, mv_code_next;
  logic [9:0]       rdo_current, rdo_current_next;
  logic [7:0]       power_status, power_status_next;
  logic [31:0]      patch_expected, patch_expected_next;
  logic [31:0]      patch_received, patch_received_next;
  logic             patch_active, patch_active_next;
  logic [7:0]       reg_pointer, reg_pointer_next;
  logic [POS_W-1:0] write_position, write_position_next;
  logic [7:0]       declared_length, declared_length_next;
  logic [31:0]      command_word, command_word_next;
  logic [POS_W-1:0] read_position, read_position_next;
  logic [31:0]      size_shadow, size_shadow_next;
  logic             ev_plug, ev_plug_next;
  logic             ev_sink, ev_sink_next;
  logic             ev_source, ev_source_next;
  logic             ev_pd, ev_pd_next;
  logic [DATA_BYTES-1:0] data_valid, data_valid_next;

  logic [7:0]         data_mem [DATA_BYTES];
  logic [7:0]         mem_rdata;
  logic               mem_we;
  logic [DATA_AW-1:0] mem_waddr;
  logic [DATA_AW-1:0] mem_raddr;
  logic               mem_re;

  stage_t s1, s1_next;
  logic   s1_valid;
  logic   out_ready, in_fire;

  cmd_t        cmd;
  logic [7:0]  in_byte;
  logic [1:0]  hdr;
  logic [POS_W-1:0] wp_inc, rp_inc, w_idx, r_idx, reg_len, stop_cnt;
  logic        pay_ok;
  logic        sink;
  logic [15:0] mv_sel;
  logic [13:0] ma_sel;
  logic [30:0] mv_prod;
  logic [26:0] ma_prod;
  logic [7:0]  reg_byte;
  logic [31:0] word_sel;

  assign cmd     = cmd_t'(s_tuser);
  assign in_byte = s_tdata;

  assign out_ready = !m_tvalid || m_tready;
  assign s_tready  = !s1_valid || out_ready;
  assign in_fire   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      strict_len    <= 1'b1;
      boot_app_mode <= 1'b0;
      charger_mv    <= 16'd5000;
      charger_ma    <= 14'd3000;
      source_mv     <= 16'd5000;
      source_ma     <= 14'd1500;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STRICT_LEN: strict_len    <= cfg_data[0];
        CFG_BOOT_APP:   boot_app_mode <= cfg_data[0];
        CFG_CHG_MV:     charger_mv    <= cfg_data;
        CFG_CHG_MA:     charger_ma    <= cfg_data[13:0];
        CFG_SRC_MV:     source_mv     <= cfg_data;
        CFG_SRC_MA:     source_ma     <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  assign sink    = (cmd == CMD_CHG_IN);
  assign mv_sel  = sink ? charger_mv : source_mv;
  assign ma_sel  = sink ? charger_ma : source_ma;
  assign mv_prod = 31'(mv_sel[15:1]) * 31'(MV_RECIP);
  assign ma_prod = 27'(ma_sel[13:1]) * 27'(MA_RECIP);

  assign hdr    = strict_len ? 2'd2 : 2'd1;
  assign wp_inc = (write_position < POS_MAX) ? write_position + 7'd1 : write_position;
  assign rp_inc = (read_position < POS_MAX) ? read_position + 7'd1 : read_position;
  assign w_idx  = write_position - POS_W'(hdr);
  assign pay_ok = !(strict_len && ({1'b0, w_idx} >= declared_length));

  always_comb begin
    stop_cnt = (write_position > POS_W'(hdr)) ? write_position - POS_W'(hdr) : '0;
    if (strict_len && (declared_length < {1'b0, stop_cnt})) begin
      stop_cnt = declared_length[POS_W-1:0];
    end
  end

  always_comb begin
    case (reg_pointer)
      ADDR_MODE, ADDR_CMD1, ADDR_RDO:     reg_len = 7'd4;
      ADDR_DATA1:                         reg_len = POS_W'(DATA_BYTES);
      ADDR_IEV, ADDR_IMSK, ADDR_ICLR:     reg_len = POS_W'(EVENT_BYTES);
      ADDR_PDO:                           reg_len = 7'd6;
      ADDR_PSTAT:                         reg_len = 7'd2;
      default:                            reg_len = '0;
    endcase
  end

  assign r_idx     = strict_len ? read_position - 7'd1 : read_position;
  assign mem_raddr = r_idx[DATA_AW-1:0];

  always_comb begin
    case (reg_pointer)
      ADDR_MODE: word_sel = mode_is_app ? FCC_APP : FCC_PTCH;
      ADDR_CMD1: word_sel = cmd_failed ? FCC_FAIL : '0;
      ADDR_PDO:  word_sel = {12'd0, mv_code, rdo_current};
      ADDR_RDO:  word_sel = {12'd0, rdo_current, 10'd0};
      default:   word_sel = '0;
    endcase
    reg_byte = 8'd0;
    case (reg_pointer)
      ADDR_MODE, ADDR_CMD1, ADDR_PDO, ADDR_RDO: begin
        if (r_idx < 7'd4) reg_byte = word_sel[8*r_idx[1:0] +: 8];
      end
      ADDR_IEV: begin
        case (r_idx)
          7'd0:    reg_byte = {4'd0, ev_plug, 3'd0};
          7'd1:    reg_byte = {2'd0, ev_source, ev_sink, 4'd0};
          7'd3:    reg_byte = {7'd0, ev_pd};
          default: reg_byte = 8'd0;
        endcase
      end
      ADDR_PSTAT: reg_byte = (r_idx == 7'd0) ? power_status : 8'd0;
      default:    reg_byte = 8'd0;
    endcase
  end

  always_comb begin
    mode_is_app_next     = mode_is_app;
    cmd_failed_next      = cmd_failed;
    mv_code_next         = mv_code;
    rdo_current_next     = rdo_current;
    power_status_next    = power_status;
    patch_expected_next  = patch_expected;
    patch_received_next  = patch_received;
    patch_active_next    = patch_active;
    reg_pointer_next     = reg_pointer;
    write_position_next  = write_position;
    declared_length_next = declared_length;
    command_word_next    = command_word;
    read_position_next   = read_position;
    size_shadow_next     = size_shadow;
    ev_plug_next         = ev_plug;
    ev_sink_next         = ev_sink;
    ev_source_next       = ev_source;
    ev_pd_next           = ev_pd;
    data_valid_next      = data_valid;
    mem_we               = 1'b0;
    mem_waddr            = w_idx[DATA_AW-1:0];
    mem_re               = 1'b0;
    s1_next              = '0;

    if (in_fire) begin
      case (cmd)
        CMD_WRITE: begin
          write_position_next = wp_inc;
          if (write_position == '0) begin
            reg_pointer_next     = in_byte;
            declared_length_next = '0;
            command_word_next    = '0;
          end else if (strict_len && (write_position == 7'd1)) begin
            declared_length_next = in_byte;
          end else if (pay_ok) begin
            if (w_idx < 7'd4) begin
              command_word_next[8*w_idx[1:0] +: 8] =
                command_word[8*w_idx[1:0] +: 8] | in_byte;
            end
            if ((reg_pointer == ADDR_DATA1) && (w_idx < POS_W'(DATA_BYTES))) begin
              mem_we = 1'b1;
              data_valid_next[w_idx[DATA_AW-1:0]] = 1'b1;
              if (w_idx < 7'd4) size_shadow_next[8*w_idx[1:0] +: 8] = in_byte;
            end
            if (reg_pointer == ADDR_ICLR) begin
              case (w_idx)
                7'd0: ev_plug_next = ev_plug & ~in_byte[3];
                7'd1: begin
                  ev_sink_next   = ev_sink & ~in_byte[4];
                  ev_source_next = ev_source & ~in_byte[5];
                end
                7'd3: ev_pd_next = ev_pd & ~in_byte[0];
                default: ;
              endcase
            end
          end
        end
        CMD_READ: begin
          read_position_next = rp_inc;
          if (strict_len && (read_position == '0)) begin
            s1_next.rd_byte = {1'b0, reg_len};
          end else if (r_idx < reg_len) begin
            if (reg_pointer == ADDR_DATA1) begin
              mem_re         = 1'b1;
              s1_next.mem_sel = 1'b1;
              s1_next.mem_ok  = data_valid[mem_raddr];
            end else begin
              s1_next.rd_byte = reg_byte;
            end
          end
        end
        CMD_STOP: begin
          if ((reg_pointer == ADDR_CMD1) && (stop_cnt >= 7'd4)) begin
            if (command_word == FCC_PBMS) begin
              if (mode_is_app) begin
                cmd_failed_next = 1'b1;
              end else begin
                patch_expected_next = size_shadow;
                patch_received_next = '0;
                patch_active_next   = 1'b1;
                cmd_failed_next     = 1'b0;
              end
            end else if (command_word == FCC_PBMC) begin
              if (patch_active && (patch_received == patch_expected)) begin
                mode_is_app_next = 1'b1;
                cmd_failed_next  = 1'b0;
              end else begin
                cmd_failed_next = 1'b1;
              end
              patch_active_next = 1'b0;
            end else if (command_word == FCC_PBME) begin
              patch_active_next = 1'b0;
              cmd_failed_next   = 1'b0;
            end else begin
              cmd_failed_next = 1'b1;
            end
          end
          write_position_next  = '0;
          read_position_next   = '0;
          declared_length_next = '0;
          command_word_next    = '0;
        end
        CMD_BURST: begin
          if (patch_active) patch_received_next = patch_received + 32'd1;
          else s1_next.nack = 1'b1;
        end
        CMD_CHG_IN, CMD_DEV_IN: begin
          power_status_next = sink ? PSTAT_SINK : PSTAT_SOURCE;
          mv_code_next      = mv_prod[29:20];
          rdo_current_next  = ma_prod[25:16];
          ev_sink_next      = ev_sink | sink;
          ev_source_next    = ev_source | !sink;
          ev_plug_next      = 1'b1;
          ev_pd_next        = 1'b1;
        end
        CMD_CHG_OUT, CMD_DEV_OUT: begin
          power_status_next = '0;
          mv_code_next      = '0;
          rdo_current_next  = '0;
          ev_plug_next      = 1'b1;
          ev_pd_next        = 1'b1;
        end
        CMD_REINIT: begin
          mode_is_app_next     = boot_app_mode;
          cmd_failed_next      = 1'b0;
          mv_code_next         = '0;
          rdo_current_next     = '0;
          power_status_next    = '0;
          patch_expected_next  = '0;
          patch_received_next  = '0;
          patch_active_next    = 1'b0;
          reg_pointer_next     = '0;
          write_position_next  = '0;
          declared_length_next = '0;
          command_word_next    = '0;
          read_position_next   = '0;
          size_shadow_next     = '0;
          ev_plug_next         = 1'b0;
          ev_sink_next         = 1'b0;
          ev_source_next       = 1'b0;
          ev_pd_next           = 1'b0;
          data_valid_next      = '0;
        end
        default: ;
      endcase
      s1_next.irq_n    = !(ev_plug_next | ev_sink_next | ev_source_next | ev_pd_next);
      s1_next.app_mode = mode_is_app_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_is_app     <= 1'b0;
      cmd_failed      <= 1'b0;
      mv_code         <= '0;
      rdo_current     <= '0;
      power_status    <= '0;
      patch_expected  <= '0;
      patch_received  <= '0;
      patch_active    <= 1'b0;
      reg_pointer     <= '0;
      write_position  <= '0;
      declared_length <= '0;
      command_word    <= '0;
      read_position   <= '0;
      size_shadow     <= '0;
      ev_plug         <= 1'b0;
      ev_sink         <= 1'b0;
      ev_source       <= 1'b0;
      ev_pd           <= 1'b0;
      data_valid      <= '0;
    end else begin
      mode_is_app     <= mode_is_app_next;
      cmd_failed      <= cmd_failed_next;
      mv_code         <= mv_code_next;
      rdo_current     <= rdo_current_next;
      power_status    <= power_status_next;
      patch_expected  <= patch_expected_next;
      patch_received  <= patch_received_next;
      patch_active    <= patch_active_next;
      reg_pointer     <= reg_pointer_next;
      write_position  <= write_position_next;
      declared_length <= declared_length_next;
      command_word    <= command_word_next;
      read_position   <= read_position_next;
      size_shadow     <= size_shadow_next;
      ev_plug         <= ev_plug_next;
      ev_sink         <= ev_sink_next;
      ev_source       <= ev_source_next;
      ev_pd           <= ev_pd_next;
      data_valid      <= data_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) data_mem[mem_waddr] <= in_byte;
  end

  always_ff @(posedge clk) begin
    if (mem_re) mem_rdata <= data_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_ready) m_tvalid <= s1_valid;
      if (in_fire) s1_valid <= 1'b1;
      else if (out_ready) s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s1 <= s1_next;
    if (out_ready && s1_valid) begin
      m_tdata[7:0]   <= s1.mem_sel ? (s1.mem_ok ? mem_rdata : 8'd0) : s1.rd_byte;
      m_tdata[8]     <= s1.nack;
      m_tdata[9]     <= s1.irq_n;
      m_tdata[10]    <= s1.app_mode;
      m_tdata[15:11] <= '0;
    end
  end

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_ready |=>
      s1_valid && $stable(s1) && (!(s1.mem_sel && s1.mem_ok) || $stable(mem_rdata)))
    else $error("read stage lost an item while the output was stalled");

  a_reinit_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && (cmd == CMD_REINIT) |=> (data_valid == '0) && !patch_active && !cmd_failed)
    else $error("reinit left state behind");

  a_nack_only_closed: assert property (@(posedge clk) disable iff (rst)
    in_fire && (cmd == CMD_BURST) && patch_active |=>
      !s1.nack && (patch_received == $past(patch_received) + 32'd1))
    else $error("burst byte mishandled while a patch is open");

endmodule
